>>> rtl/pol_pkg.sv
package pol_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int WORD_WIDTH_DEF = 32;
  localparam int POS_W_DEF      = $clog2(CAPACITY_DEF + 1);
  localparam int FIELD_W        = 32;
  localparam int OP_W           = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PTR_HOLD = 3'd0,
    PTR_LEN  = 3'd1,
    PTR_POS  = 3'd2,
    PTR_ZERO = 3'd3,
    PTR_INC  = 3'd4,
    PTR_DEC  = 3'd5
  } ptr_op_t;

  typedef enum logic {
    RA_PTR    = 1'b0,
    RA_PTR_M1 = 1'b1
  } ra_t;

  typedef enum logic {
    WA_PTR    = 1'b0,
    WA_PTR_M1 = 1'b1
  } wa_t;

  typedef enum logic {
    WD_RDATA = 1'b0,
    WD_VALUE = 1'b1
  } wd_t;

  typedef enum logic [1:0] {
    LEN_HOLD = 2'd0,
    LEN_INC  = 2'd1,
    LEN_DEC  = 2'd2
  } len_op_t;

  typedef enum logic [2:0] {
    RES_HOLD    = 3'd0,
    RES_CLEAR   = 3'd1,
    RES_OK      = 3'd2,
    RES_OK_DATA = 3'd3,
    RES_FOUND   = 3'd4
  } res_op_t;

  typedef struct packed {
    logic    load;
    ptr_op_t ptr_op;
    logic    rd_en;
    ra_t     rd_sel;
    logic    wr_en;
    wa_t     wr_sel;
    wd_t     wd_sel;
    len_op_t len_op;
    res_op_t res_op;
    logic    publish;
  } cmd_t;

  typedef struct packed {
    logic reject;
    op_t  op;
    logic ptr_at_slot;
    logic ptr_at_len;
    logic match;
  } sts_t;

endpackage

>>> rtl/pol_in_if.sv
interface pol_in_if #(
  parameter int POS_W = pol_pkg::POS_W_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic [pol_pkg::OP_W-1:0]          operation;
  logic [POS_W-1:0]                  position;
  logic signed [pol_pkg::FIELD_W-1:0] value;

  modport source (output valid, output operation, output position, output value, input ready);
  modport sink (input valid, input operation, input position, input value, output ready);
endinterface

>>> rtl/pol_out_if.sv
interface pol_out_if #(
  parameter int POS_W = pol_pkg::POS_W_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic signed [pol_pkg::FIELD_W-1:0] value_out;
  logic [POS_W-1:0]                  found_position;
  logic [POS_W-1:0]                  length_now;

  modport source (output valid, output ok, output value_out, output found_position,
                  output length_now, input ready);
  modport sink (input valid, input ok, input value_out, input found_position,
                input length_now, output ready);
endinterface

>>> rtl/pol_ctrl.sv
module pol_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  pol_pkg::sts_t sts,
  output pol_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_DISPATCH = 13'b0000000000010,
    S_UP_RD    = 13'b0000000000100,
    S_UP_WR    = 13'b0000000001000,
    S_DEL_RD   = 13'b0000000010000,
    S_DEL_CAP  = 13'b0000000100000,
    S_DN_RD    = 13'b0000001000000,
    S_DN_WR    = 13'b0000010000000,
    S_GET_RD   = 13'b0000100000000,
    S_GET_CAP  = 13'b0001000000000,
    S_LOC_RD   = 13'b0010000000000,
    S_LOC_CMP  = 13'b0100000000000,
    S_FIN      = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.res_op = pol_pkg::RES_CLEAR;
        if (sts.reject) begin
          state_nxt = S_FIN;
        end else begin
          unique case (sts.op)
            pol_pkg::OP_INSERT: begin
              cmd.ptr_op = pol_pkg::PTR_LEN;
              state_nxt  = S_UP_RD;
            end
            pol_pkg::OP_DELETE: begin
              cmd.ptr_op = pol_pkg::PTR_POS;
              state_nxt  = S_DEL_RD;
            end
            pol_pkg::OP_GET: begin
              cmd.ptr_op = pol_pkg::PTR_POS;
              state_nxt  = S_GET_RD;
            end
            pol_pkg::OP_LOCATE: begin
              cmd.ptr_op = pol_pkg::PTR_ZERO;
              state_nxt  = S_LOC_RD;
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (sts.ptr_at_slot) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = pol_pkg::WA_PTR;
          cmd.wd_sel = pol_pkg::WD_VALUE;
          cmd.len_op = pol_pkg::LEN_INC;
          cmd.res_op = pol_pkg::RES_OK;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pol_pkg::RA_PTR_M1;
          state_nxt  = S_UP_WR;
        end
      end
      S_UP_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = pol_pkg::WA_PTR;
        cmd.wd_sel = pol_pkg::WD_RDATA;
        cmd.ptr_op = pol_pkg::PTR_DEC;
        state_nxt  = S_UP_RD;
      end
      S_DEL_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = pol_pkg::RA_PTR_M1;
        state_nxt  = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        cmd.res_op = pol_pkg::RES_OK_DATA;
        state_nxt  = S_DN_RD;
      end
      S_DN_RD: begin
        if (sts.ptr_at_len) begin
          cmd.len_op = pol_pkg::LEN_DEC;
          state_nxt  = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pol_pkg::RA_PTR;
          state_nxt  = S_DN_WR;
        end
      end
      S_DN_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = pol_pkg::WA_PTR_M1;
        cmd.wd_sel = pol_pkg::WD_RDATA;
        cmd.ptr_op = pol_pkg::PTR_INC;
        state_nxt  = S_DN_RD;
      end
      S_GET_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = pol_pkg::RA_PTR_M1;
        state_nxt  = S_GET_CAP;
      end
      S_GET_CAP: begin
        cmd.res_op = pol_pkg::RES_OK_DATA;
        state_nxt  = S_FIN;
      end
      S_LOC_RD: begin
        if (sts.ptr_at_len) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = pol_pkg::RA_PTR;
          state_nxt  = S_LOC_CMP;
        end
      end
      S_LOC_CMP: begin
        if (sts.match) begin
          cmd.res_op = pol_pkg::RES_FOUND;
          state_nxt  = S_FIN;
        end else begin
          cmd.ptr_op = pol_pkg::PTR_INC;
          state_nxt  = S_LOC_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/pol_dp.sv
module pol_dp #(
  parameter int CAPACITY   = pol_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = pol_pkg::WORD_WIDTH_DEF,
  parameter int POS_W      = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pol_pkg::cmd_t                      cmd,
  output pol_pkg::sts_t                      sts,
  input  logic [pol_pkg::OP_W-1:0]           in_operation,
  input  logic [POS_W-1:0]                   in_position,
  input  logic signed [pol_pkg::FIELD_W-1:0] in_value,
  output logic                               out_ok,
  output logic signed [pol_pkg::FIELD_W-1:0] out_value_out,
  output logic [POS_W-1:0]                   out_found_position,
  output logic [POS_W-1:0]                   out_length_now
);

  localparam int AW = $clog2(CAPACITY);
  localparam int FW = pol_pkg::FIELD_W;
  localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);
  localparam logic [POS_W-1:0] ONE_P = POS_W'(1);

  logic [WORD_WIDTH-1:0] mem [CAPACITY];

  pol_pkg::op_t          op_r;
  logic [POS_W-1:0]      pos_r;
  logic [WORD_WIDTH-1:0] val_r;
  logic [POS_W-1:0]      len_r, len_nxt;
  logic [POS_W-1:0]      ptr_r, ptr_nxt;
  logic [WORD_WIDTH-1:0] rdata_r;
  logic                  res_ok_r;
  logic [WORD_WIDTH-1:0] res_val_r;
  logic [POS_W-1:0]      res_fpos_r;
  logic                  out_ok_r;
  logic [FW-1:0]         out_val_r;
  logic [POS_W-1:0]      out_fpos_r;
  logic [POS_W-1:0]      out_len_r;

  logic [FW+WORD_WIDTH-1:0] in_val_ext;
  logic [FW+WORD_WIDTH-1:0] res_val_ext;
  logic [POS_W:0]           len_p1;
  logic [POS_W-1:0]         pos_m1;
  logic [POS_W-1:0]         ptr_m1;
  logic [POS_W-1:0]         ptr_p1;
  logic [AW-1:0]            raddr;
  logic [AW-1:0]            waddr;
  logic [WORD_WIDTH-1:0]    wdata;

  assign in_val_ext  = {{WORD_WIDTH{1'b0}}, in_value};
  assign res_val_ext = {{FW{1'b0}}, res_val_r};
  assign len_p1      = {1'b0, len_r} + {{POS_W{1'b0}}, 1'b1};
  assign pos_m1      = pos_r - ONE_P;
  assign ptr_m1      = ptr_r - ONE_P;
  assign ptr_p1      = ptr_r + ONE_P;

  always_comb begin
    sts.op          = op_r;
    sts.ptr_at_slot = (ptr_r == pos_m1);
    sts.ptr_at_len  = (ptr_r == len_r);
    sts.match       = (rdata_r == val_r);
    unique case (op_r)
      pol_pkg::OP_INSERT: begin
        sts.reject = (pos_r == '0) || ({1'b0, pos_r} > len_p1) || (len_r == CAP_P);
      end
      pol_pkg::OP_DELETE, pol_pkg::OP_GET: begin
        sts.reject = (pos_r == '0) || (pos_r > len_r);
      end
      pol_pkg::OP_LOCATE: begin
        sts.reject = 1'b0;
      end
    endcase
  end

  always_comb begin
    unique case (cmd.rd_sel)
      pol_pkg::RA_PTR:    raddr = ptr_r[AW-1:0];
      pol_pkg::RA_PTR_M1: raddr = ptr_m1[AW-1:0];
    endcase
    unique case (cmd.wr_sel)
      pol_pkg::WA_PTR:    waddr = ptr_r[AW-1:0];
      pol_pkg::WA_PTR_M1: waddr = ptr_m1[AW-1:0];
    endcase
    unique case (cmd.wd_sel)
      pol_pkg::WD_RDATA: wdata = rdata_r;
      pol_pkg::WD_VALUE: wdata = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    unique case (cmd.ptr_op)
      pol_pkg::PTR_HOLD: ptr_nxt = ptr_r;
      pol_pkg::PTR_LEN:  ptr_nxt = len_r;
      pol_pkg::PTR_POS:  ptr_nxt = pos_r;
      pol_pkg::PTR_ZERO: ptr_nxt = '0;
      pol_pkg::PTR_INC:  ptr_nxt = ptr_p1;
      pol_pkg::PTR_DEC:  ptr_nxt = ptr_m1;
      default:           ptr_nxt = ptr_r;
    endcase
    unique case (cmd.len_op)
      pol_pkg::LEN_HOLD: len_nxt = len_r;
      pol_pkg::LEN_INC:  len_nxt = len_r + ONE_P;
      pol_pkg::LEN_DEC:  len_nxt = len_r - ONE_P;
      default:           len_nxt = len_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    if (cmd.load) begin
      op_r  <= pol_pkg::op_t'(in_operation);
      pos_r <= in_position;
      val_r <= in_val_ext[WORD_WIDTH-1:0];
    end
    unique case (cmd.res_op)
      pol_pkg::RES_HOLD: begin
      end
      pol_pkg::RES_CLEAR: begin
        res_ok_r   <= 1'b0;
        res_val_r  <= '0;
        res_fpos_r <= '0;
      end
      pol_pkg::RES_OK: begin
        res_ok_r <= 1'b1;
      end
      pol_pkg::RES_OK_DATA: begin
        res_ok_r  <= 1'b1;
        res_val_r <= rdata_r;
      end
      pol_pkg::RES_FOUND: begin
        res_ok_r   <= 1'b1;
        res_fpos_r <= ptr_p1;
      end
      default: begin
      end
    endcase
    if (cmd.publish) begin
      out_ok_r   <= res_ok_r;
      out_val_r  <= res_val_ext[FW-1:0];
      out_fpos_r <= res_fpos_r;
      out_len_r  <= len_r;
    end
  end

  assign out_ok             = out_ok_r;
  assign out_value_out      = out_val_r;
  assign out_found_position = out_fpos_r;
  assign out_length_now     = out_len_r;

endmodule

>>> rtl/positional_ordered_list.sv
// Channel | Direction | Handshake     | Payload
// in_if   | input     | valid / ready | operation, position, value
// out_if  | output    | valid / ready | ok, value_out, found_position, length_now
//
// Each entry that is moved or compared is first read from the single entry memory,
// which has a registered output, and is then written to its neighbouring slot or compared.
// Reset is synchronous and active low; it empties the list and drops any pending result.
// A new transaction is taken while the previous result waits; the finished result
// then holds the controller until the output register is free.
module positional_ordered_list #(
  parameter int CAPACITY   = pol_pkg::CAPACITY_DEF,
  parameter int WORD_WIDTH = pol_pkg::WORD_WIDTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pol_in_if.sink    in_if,
  pol_out_if.source out_if
);

  localparam int POS_W = $clog2(CAPACITY + 1);

  pol_pkg::cmd_t cmd;
  pol_pkg::sts_t sts;
  logic          in_ready;
  logic          out_valid;

  assign in_if.ready  = in_ready;
  assign out_if.valid = out_valid;

  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_if.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pol_dp #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH),
    .POS_W      (POS_W)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_operation       (in_if.operation),
    .in_position        (in_if.position),
    .in_value           (in_if.value),
    .out_ok             (out_if.ok),
    .out_value_out      (out_if.value_out),
    .out_found_position (out_if.found_position),
    .out_length_now     (out_if.length_now)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("A transaction was accepted while another one is in progress.");

  a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_if.valid)
    else $error("A published result did not appear on the output.");

  a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.length_now <= POS_W'(CAPACITY)))
    else $error("The reported length exceeds the capacity.");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && !out_if.ok) |-> (out_if.value_out == '0 && out_if.found_position == '0))
    else $error("A failed transaction carries a nonzero result.");

endmodule

>>> bench/pol_list_checker.sv
`timescale 1ns / 100ps

module pol_list_checker (
  input  logic      clk,
  input  logic      rst_n,
  pol_in_if         in_ch,
  pol_out_if        out_ch,
  output int        fail_count,
  output int        outstanding
);

  localparam int CAP = pol_pkg::CAPACITY_DEF;

  typedef struct {
    logic               ok;
    logic signed [31:0] value_out;
    logic [6:0]         found_position;
    logic [6:0]         length_now;
  } list_result_t;

  logic signed [31:0] slots [CAP];
  int                 slot_count;
  list_result_t       due_results [$];

  function automatic list_result_t apply_op(pol_pkg::op_t op, logic [6:0] pos,
                                            logic signed [31:0] word);
    list_result_t res;
    int           idx;
    int           p;
    res.ok             = 1'b0;
    res.value_out      = '0;
    res.found_position = '0;
    p                  = int'(pos);
    case (op)
      pol_pkg::OP_INSERT: begin
        if (p >= 1 && p <= slot_count + 1 && slot_count < CAP) begin
          for (idx = slot_count; idx > p - 1; idx--) slots[idx] = slots[idx-1];
          slots[p-1] = word;
          slot_count++;
          res.ok = 1'b1;
        end
      end
      pol_pkg::OP_DELETE: begin
        if (p >= 1 && p <= slot_count) begin
          res.value_out = slots[p-1];
          for (idx = p; idx < slot_count; idx++) slots[idx-1] = slots[idx];
          slot_count--;
          res.ok = 1'b1;
        end
      end
      pol_pkg::OP_GET: begin
        if (p >= 1 && p <= slot_count) begin
          res.value_out = slots[p-1];
          res.ok        = 1'b1;
        end
      end
      default: begin
        for (idx = 0; idx < slot_count && !res.ok; idx++) begin
          if (slots[idx] == word) begin
            res.ok             = 1'b1;
            res.found_position = 7'(idx + 1);
          end
        end
      end
    endcase
    res.length_now = 7'(slot_count);
    return res;
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst_n) begin
      fail_count = 0;
      slot_count = 0;
      due_results.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          $error("Result transaction arrived with no operation pending.");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_ch.ok !== want.ok) begin
            $error("ok: expected %0d, got %0d", want.ok, out_ch.ok);
            fail_count++;
          end
          if (out_ch.value_out !== want.value_out) begin
            $error("value_out: expected %0d, got %0d", want.value_out, out_ch.value_out);
            fail_count++;
          end
          if (out_ch.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d", want.found_position,
                   out_ch.found_position);
            fail_count++;
          end
          if (out_ch.length_now !== want.length_now) begin
            $error("length_now: expected %0d, got %0d", want.length_now, out_ch.length_now);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        due_results.push_back(apply_op(pol_pkg::op_t'(in_ch.operation), in_ch.position,
                                       in_ch.value));
      end
    end
    outstanding = due_results.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CAP = pol_pkg::CAPACITY_DEF;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   list_len;
  bit   calm;
  bit   hold_req;
  bit   hold_done;

  pol_in_if  in_ch ();
  pol_out_if out_ch ();

  positional_ordered_list u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  pol_list_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #4 clk = ~clk;

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int hold;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
    end
  end

  task automatic send_op(pol_pkg::op_t op, logic [6:0] pos, logic signed [31:0] word);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.position  <= pos;
    in_ch.value     <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == pol_pkg::OP_INSERT && pos >= 1 && pos <= list_len + 1 && list_len < CAP)
      list_len++;
    if (op == pol_pkg::OP_DELETE && pos >= 1 && pos <= list_len) list_len--;
  endtask

  function automatic logic signed [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 32'(int'($urandom_range(0, 6)) - 3);
    if (r == 4) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom;
  endfunction

  function automatic logic [6:0] pick_pos(pol_pkg::op_t op);
    if ($urandom_range(0, 6) == 0) return 7'($urandom_range(0, 127));
    if (op == pol_pkg::OP_INSERT) return 7'($urandom_range(1, list_len + 1));
    if (list_len == 0) return 7'($urandom_range(0, 127));
    return 7'($urandom_range(1, list_len));
  endfunction

  task automatic send_random_op(int insert_pct);
    int           r;
    pol_pkg::op_t op;
    r = $urandom_range(0, 99);
    if (r < insert_pct) op = pol_pkg::OP_INSERT;
    else begin
      case ($urandom_range(0, 2))
        0:       op = pol_pkg::OP_DELETE;
        1:       op = pol_pkg::OP_GET;
        default: op = pol_pkg::OP_LOCATE;
      endcase
    end
    send_op(op, pick_pos(op), pick_word());
  endtask

  initial begin
    int n;
    int waited;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= pol_pkg::OP_INSERT;
    in_ch.position  <= '0;
    in_ch.value     <= '0;
    list_len = 0;
    calm     = 1'b0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(pol_pkg::OP_GET,    7'd0,   32'sd0);
    send_op(pol_pkg::OP_GET,    7'd1,   32'sd0);
    send_op(pol_pkg::OP_DELETE, 7'd1,   32'sd0);
    send_op(pol_pkg::OP_LOCATE, 7'd0,   32'sd0);
    send_op(pol_pkg::OP_INSERT, 7'd0,   32'sd9);
    send_op(pol_pkg::OP_INSERT, 7'd2,   32'sd9);
    send_op(pol_pkg::OP_INSERT, 7'd1,   32'sh80000000);
    send_op(pol_pkg::OP_INSERT, 7'd2,   32'sh7fffffff);
    send_op(pol_pkg::OP_INSERT, 7'd1,   32'sd0);
    send_op(pol_pkg::OP_INSERT, 7'd4,   -32'sd1);
    send_op(pol_pkg::OP_INSERT, 7'd3,   -32'sd1);
    send_op(pol_pkg::OP_LOCATE, 7'd127, -32'sd1);
    send_op(pol_pkg::OP_LOCATE, 7'd0,   32'sh80000000);
    send_op(pol_pkg::OP_LOCATE, 7'd1,   32'sd5);
    send_op(pol_pkg::OP_GET,    7'd5,   32'sd0);
    send_op(pol_pkg::OP_GET,    7'd6,   32'sd0);
    send_op(pol_pkg::OP_GET,    7'd127, 32'sd0);
    send_op(pol_pkg::OP_DELETE, 7'd0,   32'sd0);
    send_op(pol_pkg::OP_DELETE, 7'd6,   32'sd0);
    send_op(pol_pkg::OP_DELETE, 7'd5,   32'sd0);
    send_op(pol_pkg::OP_DELETE, 7'd1,   32'sd0);
    send_op(pol_pkg::OP_INSERT, 7'd127, 32'sd7);
    send_op(pol_pkg::OP_GET,    7'd1,   32'sd0);
    send_op(pol_pkg::OP_LOCATE, 7'd64,  32'sh7fffffff);

    // Keep inserting after the list is full so that inserts into a full list are rejected.
    for (n = 0; n < 250; n++) send_random_op(85);

    hold_req = 1'b1;
    for (n = 0; n < 250; n++) send_random_op(40);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);

    // Drain the list so that the empty case recurs.
    for (n = 0; n < 250; n++) send_random_op(15);

    calm = 1'b1;
    for (n = 0; n < 300; n++) send_random_op(50);
    in_ch.valid <= 1'b0;

    waited = 0;
    while (outstanding != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/pol_pkg.sv
rtl/pol_in_if.sv
rtl/pol_out_if.sv
rtl/pol_ctrl.sv
rtl/pol_dp.sv
rtl/positional_ordered_list.sv
bench/pol_list_checker.sv
bench/tb_top.sv
